// ===== rtl/ecsm_pkg.sv =====
// Shared types, constants and modular helpers for the EC scalar multiplier.
package ecsm_pkg;

    localparam int WIDTH     = 32;               // scalar bits processed per item
    localparam int FIELD_W   = 32;
    localparam int IDX_W     = $clog2(WIDTH);
    localparam int T_W       = FIELD_W + 2;      // signed Bezout coefficient width
    localparam logic [FIELD_W-1:0] P_RESET = 32'd35083;

    typedef struct packed {
        logic [FIELD_W-1:0] base_x;
        logic [FIELD_W-1:0] base_y;
        logic               base_at_infinity;
        logic [FIELD_W-1:0] scalar;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] result_x;
        logic [FIELD_W-1:0] result_y;
        logic               result_at_infinity;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RED_BX,   // bxr = bx mod p
        OP_RED_BY,
        OP_RED_AX,
        OP_RED_AY,
        OP_SQ,       // t = axr^2
        OP_NUM_DBL,  // num = 3t, den = 2ayr
        OP_NUM_ADD,  // num = qy - ay, den = qx - ax
        OP_INV_INIT,
        OP_DIV,      // one Euclid step
        OP_INV_FIN,
        OP_MS,       // s = num * inv
        OP_MSS,      // t = s^2
        OP_X3A,
        OP_X3B,
        OP_DIF,      // d = axr - x3
        OP_MSD,      // t = s * d
        OP_Y3,
        OP_SET_Q,
        OP_SET_INF,
        OP_NEXT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic add;   // 1: addend is the base point, 0: doubling
    } t_ctrl;

    typedef struct packed {
        logic done;
        logic ainf;
        logic qinf;
        logic x_eq;
        logic y_eq;
        logic ay_zero;
        logic p_small;
        logic den_zero;
        logic r1_zero;
        logic r0_one;
        logic bit_set;
        logic last;
    } t_stat;

    function automatic logic [FIELD_W-1:0] modadd(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b,
                                                  input logic [FIELD_W-1:0] p);
        logic [FIELD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] modsub(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b,
                                                  input logic [FIELD_W-1:0] p);
        logic [FIELD_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            d = d + {1'b0, p};
        end
        return d[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/ecsm_modmul.sv =====
// Bit-serial modular multiplier: Horner over a, msb first.
module ecsm_modmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_a,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_b,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_p,
    output logic                         o_done,
    output logic [ecsm_pkg::FIELD_W-1:0] o_res
);
    import ecsm_pkg::*;

    localparam int CNT_W = $clog2(FIELD_W);

    logic                r_run;
    logic [CNT_W-1:0]    r_cnt;
    logic [FIELD_W-1:0]  r_a;
    logic [FIELD_W-1:0]  r_b;
    logic [FIELD_W-1:0]  r_p;
    logic [FIELD_W-1:0]  r_acc;
    logic                r_done;
    logic [FIELD_W:0]    dbl;
    logic [FIELD_W:0]    sum;

    always_comb begin
        dbl = {r_acc, 1'b0};
        if (dbl >= {1'b0, r_p}) begin
            dbl = dbl - {1'b0, r_p};
        end
        sum = dbl + (r_a[FIELD_W-1] ? {1'b0, r_b} : '0);
        if (sum >= {1'b0, r_p}) begin
            sum = sum - {1'b0, r_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_a   <= i_a;
                r_b   <= i_b;
                r_p   <= i_p;
                r_acc <= '0;
            end else if (r_run) begin
                r_acc <= sum[FIELD_W-1:0];
                r_a   <= {r_a[FIELD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FIELD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ===== rtl/ecsm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ecsm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_dividend,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [ecsm_pkg::FIELD_W-1:0] o_quot,
    output logic [ecsm_pkg::FIELD_W-1:0] o_rem
);
    import ecsm_pkg::*;

    localparam int CNT_W = $clog2(FIELD_W);

    logic               r_run;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [FIELD_W-1:0] r_q;
    logic [FIELD_W-1:0] r_rem;
    logic [FIELD_W-1:0] r_d;
    logic [FIELD_W:0]   sh;
    logic               ge;
    logic [FIELD_W:0]   diff;

    always_comb begin
        sh   = {r_rem, r_q[FIELD_W-1]};
        ge   = sh >= {1'b0, r_d};
        diff = sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_dividend;
                r_d   <= i_divisor;
                r_rem <= '0;
            end else if (r_run) begin
                r_rem <= ge ? diff[FIELD_W-1:0] : sh[FIELD_W-1:0];
                r_q   <= {r_q[FIELD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FIELD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/ecsm_datapath.sv =====
// Datapath: point registers, field ops, multiplier, inverse via extended Euclid.
module ecsm_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  ecsm_pkg::t_in                i_item,
    input  logic                         i_cfg_we,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_cfg_data,
    input  ecsm_pkg::t_ctrl              i_ctrl,
    output ecsm_pkg::t_stat              o_stat,
    output logic                         o_res_valid,
    output ecsm_pkg::t_out               o_res
);
    import ecsm_pkg::*;

    logic [FIELD_W-1:0] r_p;
    logic [FIELD_W-1:0] r_bx, r_by, r_bxr, r_byr;
    logic               r_binf;
    logic [FIELD_W-1:0] r_ax, r_ay, r_axr, r_ayr;
    logic               r_ainf;
    logic [FIELD_W-1:0] r_t, r_num, r_den, r_s, r_x3, r_d;
    logic [FIELD_W-1:0] r_r0, r_r1;
    logic [T_W-1:0]     r_t0, r_t1;
    logic [WIDTH-1:0]   r_k;
    logic [IDX_W-1:0]   r_idx;
    logic               r_done;
    t_op                r_mdst;
    logic               r_res_valid;
    t_out               r_res;

    logic               mul_start, mul_done;
    logic [FIELD_W-1:0] mul_a, mul_b, mul_res;
    logic               div_start, div_done;
    logic [FIELD_W-1:0] div_q, div_rem;
    logic [FIELD_W-1:0] qx, qy, qxr;
    logic               qinf;
    logic [T_W-1:0]     qt;
    logic [T_W-1:0]     inv_v;
    logic [FIELD_W-1:0] three_t;

    assign qx   = i_ctrl.add ? r_bx   : r_ax;
    assign qy   = i_ctrl.add ? r_by   : r_ay;
    assign qxr  = i_ctrl.add ? r_bxr  : r_axr;
    assign qinf = i_ctrl.add ? r_binf : r_ainf;

    always_comb begin
        mul_start = 1'b1;
        mul_a     = r_ax;
        mul_b     = FIELD_W'(1);
        case (i_ctrl.op)
            OP_RED_BX: mul_a = r_bx;
            OP_RED_BY: mul_a = r_by;
            OP_RED_AX: mul_a = r_ax;
            OP_RED_AY: mul_a = r_ay;
            OP_SQ: begin
                mul_a = r_axr;
                mul_b = r_axr;
            end
            OP_MS: begin
                mul_a = r_num;
                mul_b = r_den;
            end
            OP_MSS: begin
                mul_a = r_s;
                mul_b = r_s;
            end
            OP_MSD: begin
                mul_a = r_s;
                mul_b = r_d;
            end
            default: mul_start = 1'b0;
        endcase
    end

    assign div_start = (i_ctrl.op == OP_DIV);

    ecsm_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_p     (r_p),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    ecsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_r0),
        .i_divisor  (r_r1),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_rem)
    );

    // low bits of q*t1 suffice: the new coefficient stays below p in magnitude
    assign qt = T_W'({2'b00, div_q} * r_t1);

    always_comb begin
        inv_v = r_t0[T_W-1] ? r_t0 + {2'b00, r_p} : r_t0;
        if (inv_v >= {2'b00, r_p}) begin
            inv_v = inv_v - {2'b00, r_p};
        end
        three_t = modadd(modadd(r_t, r_t, r_p), r_t, r_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p         <= P_RESET;
            r_done      <= 1'b0;
            r_res_valid <= 1'b0;
            r_ainf      <= 1'b1;
            r_idx       <= '0;
            r_mdst      <= OP_NONE;
        end else begin
            r_done      <= 1'b0;
            r_res_valid <= 1'b0;
            if (i_cfg_we) begin
                r_p <= i_cfg_data;
            end
            if (i_load) begin
                r_bx   <= i_item.base_x;
                r_by   <= i_item.base_y;
                r_binf <= i_item.base_at_infinity;
                r_k    <= i_item.scalar[WIDTH-1:0];
                r_idx  <= IDX_W'(WIDTH - 1);
                r_ainf <= 1'b1;
                r_ax   <= '0;
                r_ay   <= '0;
            end
            if (mul_start) begin
                r_mdst <= i_ctrl.op;
            end
            if (mul_done) begin
                r_done <= 1'b1;
                case (r_mdst)
                    OP_RED_BX: r_bxr <= mul_res;
                    OP_RED_BY: r_byr <= mul_res;
                    OP_RED_AX: r_axr <= mul_res;
                    OP_RED_AY: r_ayr <= mul_res;
                    OP_MS:     r_s   <= mul_res;
                    default:   r_t   <= mul_res;
                endcase
            end
            if (div_done) begin
                r_done <= 1'b1;
                r_r0   <= r_r1;
                r_r1   <= div_rem;
                r_t0   <= r_t1;
                r_t1   <= r_t0 - qt;
            end
            case (i_ctrl.op)
                OP_NUM_DBL: begin
                    r_num  <= three_t;
                    r_den  <= modadd(r_ayr, r_ayr, r_p);
                    r_done <= 1'b1;
                end
                OP_NUM_ADD: begin
                    r_num  <= modsub(i_ctrl.add ? r_byr : r_ayr, r_ayr, r_p);
                    r_den  <= modsub(qxr, r_axr, r_p);
                    r_done <= 1'b1;
                end
                OP_INV_INIT: begin
                    r_r0   <= r_p;
                    r_r1   <= r_den;
                    r_t0   <= '0;
                    r_t1   <= T_W'(1);
                    r_done <= 1'b1;
                end
                OP_INV_FIN: begin
                    r_den  <= inv_v[FIELD_W-1:0];
                    r_done <= 1'b1;
                end
                OP_X3A: begin
                    r_t    <= modsub(r_t, r_axr, r_p);
                    r_done <= 1'b1;
                end
                OP_X3B: begin
                    r_x3   <= modsub(r_t, qxr, r_p);
                    r_done <= 1'b1;
                end
                OP_DIF: begin
                    r_d    <= modsub(r_axr, r_x3, r_p);
                    r_done <= 1'b1;
                end
                OP_Y3: begin
                    r_ax   <= r_x3;
                    r_ay   <= modsub(r_t, r_ayr, r_p);
                    r_ainf <= 1'b0;
                    r_done <= 1'b1;
                end
                OP_SET_Q: begin
                    r_ax   <= r_bx;
                    r_ay   <= r_by;
                    r_ainf <= r_binf;
                    r_done <= 1'b1;
                end
                OP_SET_INF: begin
                    r_ainf <= 1'b1;
                    r_done <= 1'b1;
                end
                OP_NEXT: begin
                    r_idx  <= r_idx - 1'b1;
                    r_done <= 1'b1;
                end
                OP_OUT: begin
                    r_res.result_x           <= r_ainf ? '0 : r_ax;
                    r_res.result_y           <= r_ainf ? '0 : r_ay;
                    r_res.result_at_infinity <= r_ainf;
                    r_res_valid              <= 1'b1;
                    r_done                   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.done     = r_done;
        o_stat.ainf     = r_ainf;
        o_stat.qinf     = qinf;
        o_stat.x_eq     = (r_ax == qx);
        o_stat.y_eq     = (r_ay == qy);
        o_stat.ay_zero  = (r_ay == '0);
        o_stat.p_small  = (r_p < FIELD_W'(2));
        o_stat.den_zero = (r_den == '0);
        o_stat.r1_zero  = (r_r1 == '0);
        o_stat.r0_one   = (r_r0 == FIELD_W'(1));
        o_stat.bit_set  = r_k[r_idx];
        o_stat.last     = (r_idx == '0);
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/ecsm_ctrl.sv =====
// Controller: double-and-add sequencing and point-add case selection.
module ecsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  ecsm_pkg::t_stat i_stat,
    output ecsm_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);
    import ecsm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RBY, ST_CHK, ST_RAY, ST_NUM, ST_NUMD, ST_DEN, ST_LOOP,
        ST_MS, ST_MSS, ST_X3A, ST_X3B, ST_DIF, ST_MSD, ST_Y3, ST_AFTER, ST_WAIT
    } t_state;

    t_state r_state, r_ret;
    t_op    r_op;
    logic   r_add;
    logic   r_busy;

    // every command is followed by ST_WAIT until the datapath reports done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_op    <= OP_NONE;
            r_add   <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_op <= OP_NONE;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_accept) begin
                        r_busy  <= 1'b1;
                        r_add   <= 1'b0;
                        r_op    <= OP_RED_BX;
                        r_ret   <= ST_RBY;
                        r_state <= ST_WAIT;
                    end
                end
                ST_RBY: begin
                    r_op    <= OP_RED_BY;
                    r_ret   <= ST_CHK;
                    r_state <= ST_WAIT;
                end
                ST_CHK: begin
                    if (i_stat.ainf) begin
                        if (r_add) begin
                            r_op    <= OP_SET_Q;
                            r_ret   <= ST_AFTER;
                            r_state <= ST_WAIT;
                        end else begin
                            r_state <= ST_AFTER;
                        end
                    end else if (i_stat.qinf) begin
                        r_state <= ST_AFTER;
                    end else if ((i_stat.x_eq && (!i_stat.y_eq || i_stat.ay_zero))
                                 || i_stat.p_small) begin
                        r_op    <= OP_SET_INF;
                        r_ret   <= ST_AFTER;
                        r_state <= ST_WAIT;
                    end else begin
                        r_op    <= OP_RED_AX;
                        r_ret   <= ST_RAY;
                        r_state <= ST_WAIT;
                    end
                end
                ST_RAY: begin
                    r_op    <= OP_RED_AY;
                    r_ret   <= ST_NUM;
                    r_state <= ST_WAIT;
                end
                ST_NUM: begin
                    if (i_stat.x_eq) begin
                        r_op  <= OP_SQ;
                        r_ret <= ST_NUMD;
                    end else begin
                        r_op  <= OP_NUM_ADD;
                        r_ret <= ST_DEN;
                    end
                    r_state <= ST_WAIT;
                end
                ST_NUMD: begin
                    r_op    <= OP_NUM_DBL;
                    r_ret   <= ST_DEN;
                    r_state <= ST_WAIT;
                end
                ST_DEN: begin
                    if (i_stat.den_zero) begin
                        r_op  <= OP_SET_INF;
                        r_ret <= ST_AFTER;
                    end else begin
                        r_op  <= OP_INV_INIT;
                        r_ret <= ST_LOOP;
                    end
                    r_state <= ST_WAIT;
                end
                ST_LOOP: begin
                    if (!i_stat.r1_zero) begin
                        r_op  <= OP_DIV;
                        r_ret <= ST_LOOP;
                    end else if (!i_stat.r0_one) begin
                        r_op  <= OP_SET_INF;   // no inverse: gcd above one
                        r_ret <= ST_AFTER;
                    end else begin
                        r_op  <= OP_INV_FIN;
                        r_ret <= ST_MS;
                    end
                    r_state <= ST_WAIT;
                end
                ST_MS: begin
                    r_op    <= OP_MS;
                    r_ret   <= ST_MSS;
                    r_state <= ST_WAIT;
                end
                ST_MSS: begin
                    r_op    <= OP_MSS;
                    r_ret   <= ST_X3A;
                    r_state <= ST_WAIT;
                end
                ST_X3A: begin
                    r_op    <= OP_X3A;
                    r_ret   <= ST_X3B;
                    r_state <= ST_WAIT;
                end
                ST_X3B: begin
                    r_op    <= OP_X3B;
                    r_ret   <= ST_DIF;
                    r_state <= ST_WAIT;
                end
                ST_DIF: begin
                    r_op    <= OP_DIF;
                    r_ret   <= ST_MSD;
                    r_state <= ST_WAIT;
                end
                ST_MSD: begin
                    r_op    <= OP_MSD;
                    r_ret   <= ST_Y3;
                    r_state <= ST_WAIT;
                end
                ST_Y3: begin
                    r_op    <= OP_Y3;
                    r_ret   <= ST_AFTER;
                    r_state <= ST_WAIT;
                end
                ST_AFTER: begin
                    if (!r_add && i_stat.bit_set) begin
                        r_add   <= 1'b1;
                        r_state <= ST_CHK;
                    end else if (i_stat.last) begin
                        r_op    <= OP_OUT;
                        r_ret   <= ST_IDLE;
                        r_state <= ST_WAIT;
                    end else begin
                        r_add   <= 1'b0;
                        r_op    <= OP_NEXT;
                        r_ret   <= ST_CHK;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (i_stat.done) begin
                        r_state <= r_ret;
                        if (r_ret == ST_IDLE) begin
                            r_busy <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ctrl.op  = r_op;
    assign o_ctrl.add = r_add;
    assign o_busy     = r_busy;

endmodule

// ===== rtl/ec_scalar_multiply_prime_field_top.sv =====
// Top level of the prime-field elliptic curve scalar multiplier.
//
// Usage: drive i_item (base point, infinity flag, scalar k) and raise start
// while busy is low; the beat is taken at that edge and busy rises. The block
// forms k times the base by left-to-right double-and-add over 32 scalar bits
// on y^2 = x^3 + b over GF(p). When done it pulses o_result_valid for one
// cycle with o_result; busy falls at the edge that ends that cycle. The
// receiver cannot stall; the result must be taken in its strobe cycle.
// The field modulus is written through i_cfg_valid/o_cfg_ready/i_cfg_data;
// ready is high only while idle. Reset (synchronous, active low) returns
// the modulus to 35083 and the controller to idle.
// A point operation costs two operand reductions, three (add) or four
// (double) modular multiplies on the serial multiplier, and a modular
// inverse by extended Euclid with one serial divide per quotient step and
// up to ~46 steps for a 32-bit modulus. An item also reduces the base once
// and runs 32 doublings plus one addition per set scalar bit. One item is
// in flight at a time.
module ec_scalar_multiply_prime_field_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ecsm_pkg::t_in                i_item,
    output logic                         o_result_valid,
    output ecsm_pkg::t_out               o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ecsm_pkg::FIELD_W-1:0] i_cfg_data
);
    import ecsm_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  accept;
    logic  cfg_we;

    assign accept      = start & ~busy;
    assign o_cfg_ready = ~busy;
    assign cfg_we      = i_cfg_valid & ~busy;

    ecsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    ecsm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_item      (i_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_res_valid (o_result_valid),
        .o_res       (o_result)
    );

endmodule
